// File: rtl/e2c_pkg.sv
// Shared types and tables for the epoch-seconds to UTC calendar converter.
// Used by every module in this folder; depends on nothing else.
package e2c_pkg;

    localparam int CIV_LAT = 9;
    localparam int TOD_LAT = 3;
    localparam int TOD_DLY = CIV_LAT - TOD_LAT;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_tag;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    typedef struct packed {
        logic signed [19:0] year;
        logic [3:0]         mon;
        logic [4:0]         mday;
        logic [2:0]         wday;
        logic [8:0]         yday;
    } t_date;

    // First day of each month counted from March 1, in March-based month order.
    localparam logic [8:0] MONTH_START [16] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153, 9'd184, 9'd214,
        9'd245, 9'd275, 9'd306, 9'd337, 9'd0,   9'd0,   9'd0,   9'd0
    };

endpackage

// File: rtl/e2c_daysplit.sv
// Splits offset seconds into a day number and a second of the day.
// Four register stages built on constant reciprocal multiplies; uses e2c_pkg.
module e2c_daysplit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  e2c_pkg::t_tag       i_tag,
    input  logic [43:0]         i_secs,
    output e2c_pkg::t_tag       o_tag,
    output logic [27:0]         o_zd,
    output logic [16:0]         o_tod
);

    localparam int DS_LAT = 4;
    localparam int SH_HI = 29;
    localparam int SH_LO = 38;
    localparam logic [19:0] M_HI = 20'(((64'd1 << SH_HI) + 64'd674) / 64'd675);
    localparam logic [28:0] M_LO = 29'(((64'd1 << SH_LO) + 64'd674) / 64'd675);

    e2c_pkg::t_tag r_tag [DS_LAT];

    logic [18:0] r1_uh;
    logic [17:0] r1_ul;
    logic [6:0]  r1_lo;
    logic [9:0]  r1_qh;
    logic [27:0] r2_x;
    logic [9:0]  r2_qh;
    logic [6:0]  r2_lo;
    logic [27:0] r3_x;
    logic [17:0] r3_ql;
    logic [9:0]  r3_qh;
    logic [6:0]  r3_lo;
    logic [27:0] r4_zd;
    logic [16:0] r4_tod;

    logic [38:0] w_ph;
    logic [9:0]  w_rh;
    logic [56:0] w_pl;
    logic [9:0]  w_rl;

    assign w_ph = 39'(i_secs[43:25]) * 39'(M_HI);
    assign w_rh = 10'(r1_uh - 19'(r1_qh) * 19'd675);
    assign w_pl = 57'(r2_x) * 57'(M_LO);
    assign w_rl = 10'(r3_x - 28'(r3_ql) * 28'd675);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DS_LAT; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < DS_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_uh  <= i_secs[43:25];
        r1_ul  <= i_secs[24:7];
        r1_lo  <= i_secs[6:0];
        r1_qh  <= w_ph[SH_HI+9:SH_HI];
        r2_x   <= {w_rh, r1_ul};
        r2_qh  <= r1_qh;
        r2_lo  <= r1_lo;
        r3_x   <= r2_x;
        r3_ql  <= w_pl[SH_LO+17:SH_LO];
        r3_qh  <= r2_qh;
        r3_lo  <= r2_lo;
        r4_zd  <= {r3_qh, r3_ql};
        r4_tod <= {w_rl, r3_lo};
    end

    assign o_tag = r_tag[DS_LAT-1];
    assign o_zd  = r4_zd;
    assign o_tod = r4_tod;

endmodule

// File: rtl/e2c_tod.sv
// Breaks the second of the day into hour, minute and second.
// Three arithmetic stages and a delay line that match the date path; uses e2c_pkg.
module e2c_tod (
    input  logic           i_clk,
    input  logic [16:0]    i_tod,
    output e2c_pkg::t_hms  o_hms
);

    localparam int SH_HR = 29;
    localparam int SH_MN = 18;
    localparam logic [17:0] M_HR = 18'(((64'd1 << SH_HR) + 64'd3599) / 64'd3600);
    localparam logic [12:0] M_MN = 13'(((64'd1 << SH_MN) + 64'd59) / 64'd60);

    logic [16:0] r1_tod;
    logic [4:0]  r1_hour;
    logic [11:0] r2_trem;
    logic [4:0]  r2_hour;
    logic [11:0] r3_trem;
    logic [5:0]  r3_min;
    logic [4:0]  r3_hour;
    e2c_pkg::t_hms r_dly [e2c_pkg::TOD_DLY];

    logic [34:0] w_phr;
    logic [24:0] w_pmn;
    e2c_pkg::t_hms w_hms;

    assign w_phr = 35'(i_tod) * 35'(M_HR);
    assign w_pmn = 25'(r2_trem) * 25'(M_MN);

    always_comb begin
        w_hms.hour   = r3_hour;
        w_hms.minute = r3_min;
        w_hms.second = 6'(r3_trem - 12'(r3_min) * 12'd60);
    end

    always_ff @(posedge i_clk) begin
        r1_tod  <= i_tod;
        r1_hour <= w_phr[SH_HR+4:SH_HR];
        r2_trem <= 12'(r1_tod - 17'(r1_hour) * 17'd3600);
        r2_hour <= r1_hour;
        r3_trem <= r2_trem;
        r3_min  <= w_pmn[SH_MN+5:SH_MN];
        r3_hour <= r2_hour;
        r_dly[0] <= w_hms;
        for (int k = 1; k < e2c_pkg::TOD_DLY; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    assign o_hms = r_dly[e2c_pkg::TOD_DLY-1];

endmodule

// File: rtl/e2c_civil.sv
// Turns an offset day number into year, month, day, weekday and day of year.
// Nine register stages, at most one constant reciprocal multiply deep each; uses e2c_pkg.
module e2c_civil (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  e2c_pkg::t_tag   i_tag,
    input  logic [27:0]     i_zd,
    output e2c_pkg::t_tag   o_tag,
    output e2c_pkg::t_date  o_date
);

    localparam int SH_ERA = 46;
    localparam int SH_A   = 29;
    localparam int SH_B   = 34;
    localparam int SH_W   = 21;
    localparam int SH_Y   = 27;
    localparam int SH_C   = 16;
    localparam int SH_M   = 19;
    localparam logic [28:0] M_ERA = 29'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
    localparam logic [18:0] M_A   = 19'(((64'd1 << SH_A) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_B   = 19'(((64'd1 << SH_B) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_W   = 19'(((64'd1 << SH_W) + 64'd6) / 64'd7);
    localparam logic [18:0] M_Y   = 19'(((64'd1 << SH_Y) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_C   = 10'(((64'd1 << SH_C) + 64'd99) / 64'd100);
    localparam logic [11:0] M_M   = 12'(((64'd1 << SH_M) + 64'd152) / 64'd153);
    localparam logic [20:0] YEAR_OFS = 21'd281900;

    e2c_pkg::t_tag r_tag [e2c_pkg::CIV_LAT];

    logic [27:0] r1_zd;
    logic [10:0] r1_era;
    logic [17:0] r2_doe, r2_doe3;
    logic [19:0] r2_yb;
    logic [6:0]  r3_a;
    logic [2:0]  r3_b;
    logic        r3_c;
    logic [14:0] r3_q7;
    logic [17:0] r3_doe, r3_doe3;
    logic [19:0] r3_yb;
    logic [17:0] r4_v, r4_doe;
    logic [2:0]  r4_wday;
    logic [19:0] r4_yb;
    logic [8:0]  r5_yoe;
    logic [17:0] r5_doe;
    logic [2:0]  r5_wday;
    logic [19:0] r5_yb;
    logic [1:0]  r6_y100;
    logic [8:0]  r6_yoe;
    logic [17:0] r6_doe;
    logic [2:0]  r6_wday;
    logic [19:0] r6_yb;
    logic [8:0]  r7_doy, r7_yoe;
    logic        r7_leap;
    logic [2:0]  r7_wday;
    logic [19:0] r7_yb;
    logic [3:0]  r8_mp;
    logic [8:0]  r8_doy, r8_yoe;
    logic        r8_leap;
    logic [2:0]  r8_wday;
    logic [19:0] r8_yb;
    e2c_pkg::t_date r9_date;

    logic [56:0] w_pe;
    logic [17:0] w_doe;
    logic [20:0] w_y400;
    logic [36:0] w_pa, w_pb, w_pw, w_py;
    logic [18:0] w_pc;
    logic [17:0] w_ystart;
    logic [8:0]  w_r100;
    logic [10:0] w_p5;
    logic [22:0] w_pm;
    logic        w_late;
    e2c_pkg::t_date w_date;

    assign w_pe     = 57'(i_zd) * 57'(M_ERA);
    assign w_doe    = 18'(r1_zd - 28'(r1_era) * 28'd146097);
    assign w_y400   = 21'(r1_era) * 21'd400;
    assign w_pa     = 37'(r2_doe) * 37'(M_A);
    assign w_pb     = 37'(r2_doe) * 37'(M_B);
    assign w_pw     = 37'(r2_doe3) * 37'(M_W);
    assign w_py     = 37'(r4_v) * 37'(M_Y);
    assign w_pc     = 19'(r5_yoe) * 19'(M_C);
    assign w_ystart = 18'(r6_yoe) * 18'd365 + 18'(r6_yoe[8:2]) - 18'(r6_y100);
    assign w_r100   = r6_yoe - 9'(r6_y100) * 9'd100;
    assign w_p5     = 11'(r7_doy) * 11'd5 + 11'd2;
    assign w_pm     = 23'(w_p5) * 23'(M_M);
    assign w_late   = (r8_mp >= 4'd10);

    always_comb begin
        w_date.year = $signed(r8_yb + 20'(r8_yoe) + 20'(w_late));
        w_date.mon  = w_late ? 4'(r8_mp - 4'd10) : 4'(r8_mp + 4'd2);
        w_date.mday = 5'(r8_doy - e2c_pkg::MONTH_START[r8_mp] + 9'd1);
        w_date.wday = r8_wday;
        w_date.yday = w_late ? 9'(r8_doy - 9'd306) : 9'(r8_doy + 9'd59 + 9'(r8_leap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < e2c_pkg::CIV_LAT; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < e2c_pkg::CIV_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zd   <= i_zd;
        r1_era  <= w_pe[SH_ERA+10:SH_ERA];

        r2_doe  <= w_doe;
        r2_doe3 <= w_doe + 18'd3;
        r2_yb   <= 20'(w_y400 - YEAR_OFS);

        r3_a    <= w_pa[SH_A+6:SH_A];
        r3_b    <= w_pb[SH_B+2:SH_B];
        r3_c    <= (r2_doe == 18'd146096);
        r3_q7   <= w_pw[SH_W+14:SH_W];
        r3_doe  <= r2_doe;
        r3_doe3 <= r2_doe3;
        r3_yb   <= r2_yb;

        r4_v    <= r3_doe - 18'(r3_a) + 18'(r3_b) - 18'(r3_c);
        r4_doe  <= r3_doe;
        r4_wday <= 3'(r3_doe3 - 18'(r3_q7) * 18'd7);
        r4_yb   <= r3_yb;

        r5_yoe  <= w_py[SH_Y+8:SH_Y];
        r5_doe  <= r4_doe;
        r5_wday <= r4_wday;
        r5_yb   <= r4_yb;

        r6_y100 <= w_pc[SH_C+1:SH_C];
        r6_yoe  <= r5_yoe;
        r6_doe  <= r5_doe;
        r6_wday <= r5_wday;
        r6_yb   <= r5_yb;

        r7_doy  <= 9'(r6_doe - w_ystart);
        r7_leap <= ((r6_yoe[1:0] == 2'b00) && (w_r100 != 9'd0)) || (r6_yoe == 9'd0);
        r7_yoe  <= r6_yoe;
        r7_wday <= r6_wday;
        r7_yb   <= r6_yb;

        r8_mp   <= w_pm[SH_M+3:SH_M];
        r8_doy  <= r7_doy;
        r8_leap <= r7_leap;
        r8_yoe  <= r7_yoe;
        r8_wday <= r7_wday;
        r8_yb   <= r7_yb;

        r9_date <= w_date;
    end

    assign o_tag  = r_tag[e2c_pkg::CIV_LAT-1];
    assign o_date = r9_date;

endmodule

// File: rtl/epoch_seconds_to_utc_calendar.sv
// Top level of the epoch-seconds to UTC calendar converter.
// Instantiates e2c_daysplit, e2c_tod and e2c_civil; uses e2c_pkg.
//
// The converter takes one timestamp beat in every clock cycle; o_busy is never
// raised. Each result appears on the output ports for exactly one cycle with
// o_strobe high, after one input stage, four stages that split seconds into
// day number and second of day, and nine stages that derive the calendar date,
// each stage holding at most one constant-reciprocal multiply. Results cannot
// be held off; a receiver must take every strobed beat. When o_valid_res is
// low, all other fields are zero.
module epoch_seconds_to_utc_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [43:0] i_epoch_seconds,
    output logic               o_strobe,
    output logic               o_valid_res,
    output logic signed [19:0] o_years_since_1900,
    output logic [3:0]         o_month_index,
    output logic [4:0]         o_day_of_month,
    output logic [4:0]         o_hour_of_day,
    output logic [5:0]         o_minute_of_hour,
    output logic [5:0]         o_second_of_minute,
    output logic [2:0]         o_weekday,
    output logic [8:0]         o_day_of_year
);

    localparam logic signed [43:0] SEC_LIMIT = 44'sd8640000000000;
    localparam longint OFF_DAYS = 64'sd719468 + 64'sd700 * 64'sd146097;
    localparam logic [43:0] OFF_SECS = 44'(OFF_DAYS * 64'sd86400);

    e2c_pkg::t_tag  r_tag;
    logic [43:0]    r_secs;
    e2c_pkg::t_tag  w_ds_tag, w_out_tag;
    logic [27:0]    w_zd;
    logic [16:0]    w_tod;
    e2c_pkg::t_hms  w_hms;
    e2c_pkg::t_date w_date;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag.vld <= i_start;
            r_tag.ok  <= !((i_epoch_seconds > SEC_LIMIT) || (i_epoch_seconds < -SEC_LIMIT));
        end
    end

    always_ff @(posedge i_clk) begin
        r_secs <= $unsigned(i_epoch_seconds) + OFF_SECS;
    end

    e2c_daysplit u_daysplit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag),
        .i_secs  (r_secs),
        .o_tag   (w_ds_tag),
        .o_zd    (w_zd),
        .o_tod   (w_tod)
    );

    e2c_tod u_tod (
        .i_clk (i_clk),
        .i_tod (w_tod),
        .o_hms (w_hms)
    );

    e2c_civil u_civil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_ds_tag),
        .i_zd    (w_zd),
        .o_tag   (w_out_tag),
        .o_date  (w_date)
    );

    assign o_strobe           = w_out_tag.vld;
    assign o_valid_res        = w_out_tag.ok;
    assign o_years_since_1900 = w_out_tag.ok ? w_date.year : 20'sd0;
    assign o_month_index      = w_out_tag.ok ? w_date.mon : 4'd0;
    assign o_day_of_month     = w_out_tag.ok ? w_date.mday : 5'd0;
    assign o_hour_of_day      = w_out_tag.ok ? w_hms.hour : 5'd0;
    assign o_minute_of_hour   = w_out_tag.ok ? w_hms.minute : 6'd0;
    assign o_second_of_minute = w_out_tag.ok ? w_hms.second : 6'd0;
    assign o_weekday          = w_out_tag.ok ? w_date.wday : 3'd0;
    assign o_day_of_year      = w_out_tag.ok ? w_date.yday : 9'd0;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for epoch_seconds_to_utc_calendar: directed rows, then random timestamps.
// Each accepted beat is predicted by its typed row or a local Gregorian breakdown model, checked on the strobe.
// Depends only on the RTL top level epoch_seconds_to_utc_calendar.
`timescale 1ns / 1ps

module testbench;

    localparam longint SEC_LIMIT = 64'sd8640000000000;
    localparam int     RANDOM_BEATS = 1650;

    typedef struct packed {
        logic               valid;
        logic signed [19:0] years;
        logic [3:0]         month;
        logic [4:0]         mday;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [2:0]         wday;
        logic [8:0]         yday;
    } t_cal;

    typedef struct packed {
        logic signed [43:0] secs;
        logic               typed;
        t_cal               cal;
    } t_row;

    localparam t_cal CAL_OUT_OF_RANGE = '0;
    localparam t_cal CAL_EPOCH = '{1'b1, 20'sd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4, 9'd0};
    localparam t_cal CAL_EPOCH_MINUS_1 =
        '{1'b1, 20'sd69, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59, 3'd3, 9'd364};

    localparam int N_ROWS = 22;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{44'sd0,                1'b1, CAL_EPOCH},
        '{-44'sd1,               1'b1, CAL_EPOCH_MINUS_1},
        '{44'sd8640000000001,    1'b1, CAL_OUT_OF_RANGE},
        '{-44'sd8640000000001,   1'b1, CAL_OUT_OF_RANGE},
        '{44'sh7FFFFFFFFFF,      1'b1, CAL_OUT_OF_RANGE},
        '{44'sh80000000000,      1'b1, CAL_OUT_OF_RANGE},
        '{44'sd8640000000000,    1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd8640000000000,   1'b0, CAL_OUT_OF_RANGE},
        '{44'sd86399,            1'b0, CAL_OUT_OF_RANGE},
        '{44'sd86400,            1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd86400,           1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd86401,           1'b0, CAL_OUT_OF_RANGE},
        '{44'sd951782399,        1'b0, CAL_OUT_OF_RANGE},
        '{44'sd951782400,        1'b0, CAL_OUT_OF_RANGE},
        '{44'sd951868800,        1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd2203891200,      1'b0, CAL_OUT_OF_RANGE},
        '{44'sd1735689599,       1'b0, CAL_OUT_OF_RANGE},
        '{44'sd4107542400,       1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd62162035200,     1'b0, CAL_OUT_OF_RANGE},
        '{-44'sd62162035201,     1'b0, CAL_OUT_OF_RANGE},
        '{44'sh55555555555,      1'b0, CAL_OUT_OF_RANGE},
        '{44'shAAAAAAAAAAA,      1'b0, CAL_OUT_OF_RANGE}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [43:0] i_epoch_seconds;
    logic               o_strobe;
    logic               o_valid_res;
    logic signed [19:0] o_years_since_1900;
    logic [3:0]         o_month_index;
    logic [4:0]         o_day_of_month;
    logic [4:0]         o_hour_of_day;
    logic [5:0]         o_minute_of_hour;
    logic [5:0]         o_second_of_minute;
    logic [2:0]         o_weekday;
    logic [8:0]         o_day_of_year;

    logic beat_typed;
    t_cal beat_cal;
    t_cal calendar_due_q [$];
    int   mismatch_count = 0;

    epoch_seconds_to_utc_calendar u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_strobe           (o_strobe),
        .o_valid_res        (o_valid_res),
        .o_years_since_1900 (o_years_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_weekday          (o_weekday),
        .o_day_of_year      (o_day_of_year)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_cal utc_breakdown(logic signed [43:0] secs);
        longint t, days, tod, shifted, era, day_of_era, year_of_era, march_day, march_mon;
        longint year, day_in_year, wday;
        bit     leap;
        t_cal   c;
        c = CAL_OUT_OF_RANGE;
        t = secs;
        if (t > SEC_LIMIT || t < -SEC_LIMIT) return c;
        days = floor_quot(t, 86400);
        tod = t - days * 86400;
        shifted = days + 719468;
        era = floor_quot(shifted, 146097);
        day_of_era = shifted - era * 146097;
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        march_day = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
        march_mon = (5 * march_day + 2) / 153;
        year = year_of_era + era * 400 + ((march_mon >= 10) ? 1 : 0);
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        if (march_mon >= 10) day_in_year = march_day - 306;
        else day_in_year = march_day + 59 + (leap ? 1 : 0);
        wday = days + 4 - 7 * floor_quot(days + 4, 7);
        c.valid = 1'b1;
        c.years = 20'(year - 1900);
        c.month = 4'((march_mon < 10) ? march_mon + 2 : march_mon - 10);
        c.mday = 5'(march_day - (153 * march_mon + 2) / 5 + 1);
        c.hour = 5'(tod / 3600);
        c.minute = 6'((tod % 3600) / 60);
        c.second = 6'(tod % 60);
        c.wday = 3'(wday);
        c.yday = 9'(day_in_year);
        return c;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cal due;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (calendar_due_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    mismatch_count++;
                end else begin
                    due = calendar_due_q.pop_front();
                    check_field("valid_res", due.valid, o_valid_res);
                    check_field("years_since_1900", $signed(due.years), o_years_since_1900);
                    check_field("month_index", due.month, o_month_index);
                    check_field("day_of_month", due.mday, o_day_of_month);
                    check_field("hour_of_day", due.hour, o_hour_of_day);
                    check_field("minute_of_hour", due.minute, o_minute_of_hour);
                    check_field("second_of_minute", due.second, o_second_of_minute);
                    check_field("weekday", due.wday, o_weekday);
                    check_field("day_of_year", due.yday, o_day_of_year);
                end
            end
            if (i_start && !o_busy) begin
                if (beat_typed) calendar_due_q.push_back(beat_cal);
                else calendar_due_q.push_back(utc_breakdown(i_epoch_seconds));
            end
        end
    end

    task automatic send_timestamp(logic signed [43:0] secs, logic typed, t_cal cal);
        i_start <= 1'b1;
        i_epoch_seconds <= secs;
        beat_typed <= typed;
        beat_cal <= cal;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (calendar_due_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [43:0] random_timestamp();
        longint unsigned r;
        longint          v;
        int              pick;
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            v = longint'(r % longint'(2 * SEC_LIMIT + 1)) - SEC_LIMIT;
        end else if (pick < 70) begin
            v = longint'(44'(r));
            return 44'(r);
        end else if (pick < 80) begin
            v = ($urandom_range(0, 1) ? SEC_LIMIT : -SEC_LIMIT) + $signed($urandom_range(0, 6)) - 3;
        end else if (pick < 92) begin
            v = (longint'($urandom_range(0, 146097)) - 73048) * 86400
                + $signed($urandom_range(0, 2)) - 1;
        end else begin
            v = longint'($urandom_range(0, 2000000)) - 1000000;
        end
        return 44'(v);
    endfunction

    initial begin
        int burst;
        int sent;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_epoch_seconds <= '0;
        beat_typed <= 1'b0;
        beat_cal <= CAL_OUT_OF_RANGE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            send_timestamp(DIRECTED_ROWS[k].secs, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].cal);
        end
        drain_results();

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
                send_timestamp(random_timestamp(), 1'b0, CAL_OUT_OF_RANGE);
                sent++;
                if (sent == RANDOM_BEATS / 2) drain_results();
            end
            if ($urandom_range(0, 3) != 0 && sent < RANDOM_BEATS) begin
                pause_sender($urandom_range(1, 6));
            end
        end
        drain_results();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
